// ===== rtl/rxem_pkg.sv =====
// Shared constants, types and helpers for the receive error window monitor.
package rxem_pkg;

  localparam int unsigned Window   = 16;
  localparam int unsigned CountW   = 16;
  localparam int unsigned NumCh    = 5;
  localparam int unsigned DeltaW   = NumCh * CountW;
  localparam int unsigned SumW     = CountW + $clog2(Window);
  localparam int unsigned OutSumW  = 20;
  localparam int unsigned TotalW   = 22;
  localparam int unsigned SatW     = (SumW > OutSumW) ? SumW : OutSumW;
  localparam int unsigned InDataW  = DeltaW;
  localparam int unsigned OutPackW = NumCh * OutSumW + TotalW;
  localparam int unsigned OutDataW = ((OutPackW + 7) / 8) * 8;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [OutSumW-1:0] SumMax = '1;

  // channel slots in the delta vector and the output word
  localparam int unsigned ChOfdmGlitch   = 0;
  localparam int unsigned ChOfdmBadhdr   = 1;
  localparam int unsigned ChLegacyGlitch = 2;
  localparam int unsigned ChLegacyBadhdr = 3;
  localparam int unsigned ChBadfcs       = 4;

  // input counter slots in tdata
  localparam int unsigned InTotalGlitch  = 0;
  localparam int unsigned InTotalBadhdr  = 1;
  localparam int unsigned InLegacyGlitch = 2;
  localparam int unsigned InLegacyBadhdr = 3;
  localparam int unsigned InBadfcs       = 4;

  typedef enum logic [CfgIdxW-1:0] {
    CfgClampLegacy  = 2'd0,
    CfgBadhdrLimit  = 2'd1,
    CfgGlitchLimit  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic              clamp;
    logic [CountW-1:0] badhdr_limit;
    logic [CountW-1:0] glitch_limit;
  } cfg_t;

  function automatic logic [OutSumW-1:0] sat_sum(input logic [SumW-1:0] s);
    logic [SatW-1:0] ext;
    ext = SatW'(s);
    if (ext > SatW'(SumMax)) begin
      return SumMax;
    end
    return ext[OutSumW-1:0];
  endfunction

endpackage

// ===== rtl/rxem_cell.sv =====
// One history cell: holds the five deltas of one tick and passes them on.
module rxem_cell
  import rxem_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              shift_i,
  input  logic [DeltaW-1:0] data_i,
  output logic [DeltaW-1:0] data_o
);

  logic [DeltaW-1:0] data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else if (shift_i) begin
      data_q <= data_i;
    end
  end

  assign data_o = data_q;

endmodule

// ===== rtl/rxem_delta.sv =====
// Wrap-around counter deltas, OFDM split and legacy clamping.
module rxem_delta
  import rxem_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic [InDataW-1:0] counts_i,
  input  cfg_t               cfg_i,
  output logic [DeltaW-1:0]  delta_o
);

  logic [CountW-1:0] prev_q [NumCh];
  logic [CountW-1:0] raw [NumCh];
  logic [CountW-1:0] lg_clamped, lb_clamped;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NumCh; c++) prev_q[c] <= '0;
    end else if (en_i) begin
      for (int c = 0; c < NumCh; c++) prev_q[c] <= counts_i[c*CountW +: CountW];
    end
  end

  always_comb begin
    for (int c = 0; c < NumCh; c++) begin
      raw[c] = counts_i[c*CountW +: CountW] - prev_q[c];
    end
  end

  // ofdm deltas use the unclamped legacy deltas
  always_comb begin
    lg_clamped = raw[InLegacyGlitch];
    lb_clamped = raw[InLegacyBadhdr];
    if (cfg_i.clamp && (raw[InLegacyGlitch] > cfg_i.glitch_limit)) begin
      lg_clamped = cfg_i.glitch_limit;
    end
    if (cfg_i.clamp && (raw[InLegacyBadhdr] > cfg_i.badhdr_limit)) begin
      lb_clamped = cfg_i.badhdr_limit;
    end
  end

  always_comb begin
    delta_o = '0;
    delta_o[ChOfdmGlitch*CountW +: CountW]   = raw[InTotalGlitch] - raw[InLegacyGlitch];
    delta_o[ChOfdmBadhdr*CountW +: CountW]   = raw[InTotalBadhdr] - raw[InLegacyBadhdr];
    delta_o[ChLegacyGlitch*CountW +: CountW] = lg_clamped;
    delta_o[ChLegacyBadhdr*CountW +: CountW] = lb_clamped;
    delta_o[ChBadfcs*CountW +: CountW]       = raw[InBadfcs];
  end

endmodule

// ===== rtl/rx_error_counter_window_monitor_top.sv =====
// Top level: window sums of receive error counter deltas over a cell chain.
//
//  channel   direction  payload (low bits first)
//  s_axis    in         total_glitch, total_badhdr, legacy_glitch, legacy_badhdr, badfcs
//  m_axis    out        ofdm_glitch, ofdm_badhdr, legacy_glitch, legacy_badhdr, badfcs,
//                       interference_total
//  cfg       in         index, data (clamp_legacy, legacy_badhdr_limit, legacy_glitch_limit)
//
// One transaction per cycle sustained while the output is not stalled; a result passes
// through the accumulate stage (five running-sum lanes fed from the cell chain) and
// then the output stage that adds the interference total.
// Reset clears the counters, running sums and every history cell at once.
// A stalled output holds its result while one more input waits in the sum stage.
module rx_error_counter_window_monitor_top
  import rxem_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // total_glitch[15:0], total_badhdr[31:16], legacy_glitch[47:32],
  // legacy_badhdr[63:48], badfcs[79:64]
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // ofdm_glitch[19:0], ofdm_badhdr[39:20], legacy_glitch[59:40],
  // legacy_badhdr[79:60], badfcs[99:80], interference_total[121:100], zero pad
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CountW-1:0]   cfg_data_i
);

  cfg_t cfg_q, cfg_d;

  logic in_acc, s1_adv;
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;

  logic [DeltaW-1:0]   delta;
  logic [DeltaW-1:0]   chain [Window+1];
  logic [SumW-1:0]     sum_q [NumCh];
  logic [SumW-1:0]     sum_d [NumCh];
  logic [OutSumW-1:0]  s1_sum_q [NumCh];
  logic [OutSumW-1:0]  s1_sum_d [NumCh];
  logic [OutDataW-1:0] out_data_q, out_data_d;
  logic [TotalW-1:0]   total;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgClampLegacy: cfg_d.clamp        = cfg_data_i[0];
        CfgBadhdrLimit: cfg_d.badhdr_limit = cfg_data_i;
        CfgGlitchLimit: cfg_d.glitch_limit = cfg_data_i;
        default:        cfg_d              = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clamp        <= 1'b0;
      cfg_q.badhdr_limit <= '1;
      cfg_q.glitch_limit <= '1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // handshake
  assign s1_adv        = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  rxem_delta u_delta (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (in_acc),
    .counts_i (s_axis_tdata),
    .cfg_i    (cfg_q),
    .delta_o  (delta)
  );

  // history: cell 0 holds the newest tick, the last cell's output drops out
  assign chain[0] = delta;

  for (genvar i = 0; i < Window; i++) begin : g_cell
    rxem_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(in_acc),
      .data_i (chain[i]),
      .data_o (chain[i+1])
    );
  end

  always_comb begin
    for (int c = 0; c < NumCh; c++) begin
      sum_d[c] = sum_q[c] + SumW'(delta[c*CountW +: CountW])
                          - SumW'(chain[Window][c*CountW +: CountW]);
      s1_sum_d[c] = sat_sum(sum_d[c]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NumCh; c++) sum_q[c] <= '0;
    end else if (in_acc) begin
      for (int c = 0; c < NumCh; c++) sum_q[c] <= sum_d[c];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int c = 0; c < NumCh; c++) s1_sum_q[c] <= s1_sum_d[c];
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  // output stage
  assign total = TotalW'(s1_sum_q[ChOfdmGlitch]) + TotalW'(s1_sum_q[ChOfdmBadhdr])
               + TotalW'(s1_sum_q[ChLegacyGlitch]) + TotalW'(s1_sum_q[ChLegacyBadhdr]);

  always_comb begin
    out_data_d = '0;
    for (int c = 0; c < NumCh; c++) begin
      out_data_d[c*OutSumW +: OutSumW] = s1_sum_q[c];
    end
    out_data_d[NumCh*OutSumW +: TotalW] = total;
  end

  assign out_valid_d = s1_adv ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      out_data_q <= out_data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // checks
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (!s1_valid_q || s1_adv))
    else $error("input taken while sum stage is blocked");

  a_sum_stage_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> s1_valid_q)
    else $error("accepted transaction missing from sum stage");

  a_out_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_adv) |=> out_valid_q)
    else $error("sum stage result not moved to output");

  a_clamp_glitch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && cfg_q.clamp) |->
      (delta[ChLegacyGlitch*CountW +: CountW] <= cfg_q.glitch_limit))
    else $error("legacy glitch delta above limit in clamp mode");

  a_clamp_badhdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && cfg_q.clamp) |->
      (delta[ChLegacyBadhdr*CountW +: CountW] <= cfg_q.badhdr_limit))
    else $error("legacy bad header delta above limit in clamp mode");

endmodule
